[sv/bgn_pkg.sv]
// shared types, widths and constants of the block gain normalizer
package bgn_pkg;

   // fixed widths of the datapath
   localparam int MAX_BLOCK      = 4096;
   localparam int SAMPLE_BITS    = 24;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int GAIN_BITS      = 16;
   localparam int OUT_BITS       = 28;
   localparam int POS_BITS       = $clog2(MAX_BLOCK);
   localparam int LEN_BITS       = 13;
   localparam int LEVEL_BITS     = 23;
   localparam int SUM_BITS       = 36;
   localparam int DIV_BITS       = 36;
   localparam int DIV_COUNT_BITS = $clog2(DIV_BITS + 1);
   localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 23;

   // register reset values
   localparam logic [LEN_BITS-1:0]   BLOCK_LENGTH_RESET = LEN_BITS'(1920);
   localparam logic [LEVEL_BITS-1:0] TARGET_LEVEL_RESET = LEVEL_BITS'(838861);
   localparam logic [LEVEL_BITS-1:0] LEVEL_FLOOR_RESET  = LEVEL_BITS'(8);
   localparam logic [GAIN_BITS-1:0]  GAIN_MIN_RESET     = GAIN_BITS'(410);
   localparam logic [GAIN_BITS-1:0]  GAIN_MAX_RESET     = GAIN_BITS'(40960);
   localparam logic [GAIN_BITS-1:0]  UNITY_GAIN         = GAIN_BITS'(1 << GAIN_FRAC_BITS);

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BLOCK_LENGTH = 3'd0,
      CSR_TARGET_LEVEL = 3'd1,
      CSR_LEVEL_FLOOR  = 3'd2,
      CSR_GAIN_MIN     = 3'd3,
      CSR_GAIN_MAX     = 3'd4
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCALE,
      ST_DIV_LEVEL,
      ST_DIV_GAIN
   } state_type;

   // divider request and response
   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[sv/bgn_if.sv]
// item channels of the block gain normalizer

// sample channel
interface bgn_req_if import bgn_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// scaled sample channel
interface bgn_rsp_if import bgn_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] scaled_sample;
   logic [GAIN_BITS-1:0]       applied_gain;
   logic                       end_of_block;

   modport source (output valid, output scaled_sample, output applied_gain,
                   output end_of_block, input ready);
   modport sink (input valid, input scaled_sample, input applied_gain,
                 input end_of_block, output ready);
endinterface

[sv/bgn_ram.sv]
// single port synchronous ram, read before write, registered read data
module bgn_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // old contents come out while the new word goes in
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

[sv/bgn_divider.sv]
// restoring divider, one quotient bit per cycle
module bgn_divider import bgn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                      busy_ff, busy_in;
   logic [DIV_COUNT_BITS-1:0] count_ff, count_in;
   logic [DIV_BITS-1:0]       rem_ff, rem_in;
   logic [DIV_BITS-1:0]       quo_ff, quo_in;
   logic [DIV_BITS-1:0]       dsr_ff, dsr_in;
   logic [DIV_BITS:0]         shifted;
   logic [DIV_BITS+1:0]       trial;

   // one trial subtraction
   assign shifted = {rem_ff, quo_ff[DIV_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = DIV_COUNT_BITS'(DIV_BITS);
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
      end else if (busy_ff) begin
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
            if (!trial[DIV_BITS+1]) begin
               rem_in = trial[DIV_BITS-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = shifted[DIV_BITS-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
            end
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   // quotient holds after the last step
   assign div_rsp.done     = busy_ff && (count_ff == '0);
   assign div_rsp.quotient = quo_ff;

endmodule

[sv/block_gain_normalizer.sv]
// top level of the block gain normalizer
//
//   channel  direction  payload                                   accepted when
//   req_ch   in         sample_in                                 valid & ready
//   rsp_ch   out        scaled_sample, applied_gain, end_of_block valid & ready
//   csr_*    in         csr_index, csr_wdata                      csr_we
//
// an item goes through accept and store access, product, then scale and output
// the last item of a block adds the level division on the shared divider,
// and the gain division after it when the level is above the floor
// once a block is stored, the scale step waits for as long as the output register holds an item not yet taken
// synchronous reset; sample store contents are not cleared by reset
// a full output register stalls the sequencer and with it the next accept
module block_gain_normalizer import bgn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   bgn_req_if.sink                   req_ch,
   bgn_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration registers
   logic [LEN_BITS-1:0]   block_length_ff;
   logic [LEVEL_BITS-1:0] target_level_ff;
   logic [LEVEL_BITS-1:0] level_floor_ff;
   logic [GAIN_BITS-1:0]  gain_min_ff;
   logic [GAIN_BITS-1:0]  gain_max_ff;

   // sequencer and block state
   state_type                    state_ff, state_in;
   logic [POS_BITS-1:0]          pos_ff, pos_in;
   logic [SUM_BITS-1:0]          sum_ff, sum_in;
   logic [GAIN_BITS-1:0]         gain_ff, gain_in;
   logic                         primed_ff, primed_in;
   logic                         last_ff, last_in;
   logic [LEN_BITS-1:0]          len_ff, len_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]   scaled_ff, scaled_in;
   logic [GAIN_BITS-1:0]         out_gain_ff, out_gain_in;
   logic                         eob_ff, eob_in;

   // datapath helpers
   logic                         accept;
   logic [LEN_BITS-1:0]          eff_len;
   logic                         is_last;
   logic [SAMPLE_BITS-1:0]       abs_sample;
   logic [SAMPLE_BITS-1:0]       ram_rdata;
   logic signed [PROD_BITS-1:0]  shifted;
   logic [PROD_BITS-OUT_BITS:0]  upper;
   logic signed [OUT_BITS-1:0]   saturated;
   logic                         out_free;
   div_req_type                  div_req;
   div_rsp_type                  div_rsp;

   // clamp a quotient to the gain window, maximum applied last
   function automatic logic [GAIN_BITS-1:0] clamp_gain(
      input logic [DIV_BITS-1:0]  g,
      input logic [GAIN_BITS-1:0] gmin,
      input logic [GAIN_BITS-1:0] gmax
   );
      logic [DIV_BITS-1:0] t;
      t = g;
      if (t < DIV_BITS'(gmin)) begin
         t = DIV_BITS'(gmin);
      end
      if (t > DIV_BITS'(gmax)) begin
         t = DIV_BITS'(gmax);
      end
      return t[GAIN_BITS-1:0];
   endfunction

   // configuration writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= BLOCK_LENGTH_RESET;
         target_level_ff <= TARGET_LEVEL_RESET;
         level_floor_ff  <= LEVEL_FLOOR_RESET;
         gain_min_ff     <= GAIN_MIN_RESET;
         gain_max_ff     <= GAIN_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_LENGTH: block_length_ff <= csr_wdata[LEN_BITS-1:0];
            CSR_TARGET_LEVEL: target_level_ff <= csr_wdata[LEVEL_BITS-1:0];
            CSR_LEVEL_FLOOR:  level_floor_ff  <= csr_wdata[LEVEL_BITS-1:0];
            CSR_GAIN_MIN:     gain_min_ff     <= csr_wdata[GAIN_BITS-1:0];
            CSR_GAIN_MAX:     gain_max_ff     <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective block length and end of block detection
   always_comb begin
      eff_len = block_length_ff;
      if (block_length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (block_length_ff > LEN_BITS'(MAX_BLOCK)) begin
         eff_len = LEN_BITS'(MAX_BLOCK);
      end
   end

   assign is_last    = ({1'b0, pos_ff} + 1'b1) >= eff_len;
   assign abs_sample = req_ch.sample_in[SAMPLE_BITS-1] ? (~req_ch.sample_in + 1'b1)
                                                        : req_ch.sample_in;
   assign accept     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // sample store: new sample in, previous block's sample out
   bgn_ram #(
      .DEPTH (MAX_BLOCK),
      .WIDTH (SAMPLE_BITS)
   ) u_store (
      .clock (clock),
      .we    (accept),
      .addr  (pos_ff),
      .wdata (req_ch.sample_in),
      .rdata (ram_rdata)
   );

   // shared divider for level and gain
   bgn_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // floor shift and saturation of the product
   assign shifted = prod_ff >>> GAIN_FRAC_BITS;
   assign upper   = shifted[PROD_BITS-1:OUT_BITS-1];
   always_comb begin
      if (upper == '0 || upper == '1) begin
         saturated = shifted[OUT_BITS-1:0];
      end else if (shifted[PROD_BITS-1]) begin
         saturated = {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         saturated = {1'b0, {(OUT_BITS-1){1'b1}}};
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      gain_in      = gain_ff;
      primed_in    = primed_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      scaled_in    = scaled_ff;
      out_gain_in  = out_gain_ff;
      eob_in       = eob_ff;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in   = sum_ff + SUM_BITS'(abs_sample);
               last_in  = is_last;
               len_in   = eff_len;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // signed sample times unsigned gain, both extended to the product width
            prod_in  = $signed({{(PROD_BITS-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}},
                                ram_rdata})
                     * $signed({{(PROD_BITS-GAIN_BITS){1'b0}}, gain_ff});
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (!primed_ff || out_free) begin
               if (primed_ff) begin
                  rsp_valid_in = 1'b1;
                  scaled_in    = saturated;
                  out_gain_in  = gain_ff;
                  eob_in       = last_ff;
               end
               if (last_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_BITS'(sum_ff);
                  div_req.divisor  = DIV_BITS'(len_ff);
                  sum_in           = '0;
                  pos_in           = '0;
                  primed_in        = 1'b1;
                  state_in         = ST_DIV_LEVEL;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV_LEVEL: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > DIV_BITS'(level_floor_ff)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_BITS'({target_level_ff, {GAIN_FRAC_BITS{1'b0}}});
                  div_req.divisor  = div_rsp.quotient;
                  state_in         = ST_DIV_GAIN;
               end else begin
                  gain_in  = clamp_gain(DIV_BITS'(UNITY_GAIN), gain_min_ff, gain_max_ff);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV_GAIN: begin
            if (div_rsp.done) begin
               gain_in  = clamp_gain(div_rsp.quotient, gain_min_ff, gain_max_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sum_ff       <= '0;
         gain_ff      <= UNITY_GAIN;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         gain_ff      <= gain_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      len_ff      <= len_in;
      prod_ff     <= prod_in;
      scaled_ff   <= scaled_in;
      out_gain_ff <= out_gain_in;
      eob_ff      <= eob_in;
   end

   // result channel
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.scaled_sample = scaled_ff;
   assign rsp_ch.applied_gain  = out_gain_ff;
   assign rsp_ch.end_of_block  = eob_ff;

endmodule

[sv/bgn_checker.sv]
// port level checks of the block gain normalizer and their binding
module bgn_checker import bgn_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [OUT_BITS-1:0] rsp_scaled_sample,
   input logic [GAIN_BITS-1:0]       rsp_applied_gain,
   input logic                       rsp_end_of_block
);

   // no result survives a reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one item at a time: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after an accepted item");

   // a waiting result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // a waiting result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_scaled_sample) && $stable(rsp_applied_gain)
          && $stable(rsp_end_of_block)))
      else $error("result payload changed while stalled");

endmodule

bind block_gain_normalizer bgn_checker u_bgn_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_scaled_sample (rsp_ch.scaled_sample),
   .rsp_applied_gain  (rsp_ch.applied_gain),
   .rsp_end_of_block  (rsp_ch.end_of_block)
);

[sim/tb_block_gain_normalizer.sv]
// testbench for the block gain normalizer: directed plan, random phases, scoreboard
`timescale 1ns / 100ps

module tb_block_gain_normalizer;
   import bgn_pkg::*;

   // run limits and timing
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_ITEMS  = 700;
   localparam int PRIME_LEN     = 128;
   localparam int MAX_IDLE      = 13;
   localparam int REPORT_LIMIT  = 10;

   // field extremes
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int LEVEL_MAX     = (1 << LEVEL_BITS) - 1;
   localparam int GAIN_MAX      = (1 << GAIN_BITS) - 1;
   localparam int GAIN_ONE      = int'(UNITY_GAIN);
   localparam int LEN_FIELD_MAX = (1 << LEN_BITS) - 1;

   // register indexes outside the five registers
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] scaled;
      logic [GAIN_BITS-1:0]       gain;
      logic                       eob;
   } scaled_item_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [CSR_INDEX_BITS-1:0]     index;
      logic [CSR_DATA_BITS-1:0]      value;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          typed;
      scaled_item_type               result;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   bgn_req_if req_ch ();
   bgn_rsp_if rsp_ch ();

   block_gain_normalizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register mirror
   logic [LEN_BITS-1:0]   cfg_block_length = BLOCK_LENGTH_RESET;
   logic [LEVEL_BITS-1:0] cfg_target       = TARGET_LEVEL_RESET;
   logic [LEVEL_BITS-1:0] cfg_floor        = LEVEL_FLOOR_RESET;
   logic [GAIN_BITS-1:0]  cfg_gain_min     = GAIN_MIN_RESET;
   logic [GAIN_BITS-1:0]  cfg_gain_max     = GAIN_MAX_RESET;

   // predictor state
   logic signed [SAMPLE_BITS-1:0] held_samples [MAX_BLOCK];
   int unsigned                   wr_slot     = 0;
   logic [SUM_BITS-1:0]           run_abs_sum = '0;
   logic [GAIN_BITS-1:0]          gain_now    = UNITY_GAIN;
   bit                            have_block  = 1'b0;

   scaled_item_type scaled_due [$];
   plan_row_type    plan [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   bit              req_idles      = 1'b1;
   bit              rsp_idles      = 1'b1;

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // previous-block sample times its gain, floor shift, saturated
   function automatic logic signed [OUT_BITS-1:0] apply_gain(
      input logic signed [SAMPLE_BITS-1:0] v, input logic [GAIN_BITS-1:0] g);
      longint p;
      p = longint'(v) * longint'(g);
      p = p >>> GAIN_FRAC_BITS;
      if (p > (longint'(1) << (OUT_BITS - 1)) - 1) p = (longint'(1) << (OUT_BITS - 1)) - 1;
      if (p < -(longint'(1) << (OUT_BITS - 1))) p = -(longint'(1) << (OUT_BITS - 1));
      return p[OUT_BITS-1:0];
   endfunction

   // gain for the next block from the mean absolute level
   function automatic logic [GAIN_BITS-1:0] block_gain_for(input int unsigned len);
      longint unsigned level;
      longint unsigned g;
      level = longint'(run_abs_sum) / len;
      if (level > 64'(cfg_floor)) g = (longint'(cfg_target) << GAIN_FRAC_BITS) / level;
      else g = 64'(UNITY_GAIN);
      if (g < 64'(cfg_gain_min)) g = 64'(cfg_gain_min);
      if (g > 64'(cfg_gain_max)) g = 64'(cfg_gain_max);
      return g[GAIN_BITS-1:0];
   endfunction

   // store the sample, return the scaled previous-block sample if primed
   function automatic bit predict_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                         output scaled_item_type r);
      int unsigned len;
      bit          last;
      bit          produces;
      longint      mag;
      logic signed [SAMPLE_BITS-1:0] old;
      len = int'(cfg_block_length);
      if (len == 0) len = 1;
      if (len > MAX_BLOCK) len = MAX_BLOCK;
      last = (wr_slot + 1 >= len);
      old  = held_samples[wr_slot[POS_BITS-1:0]];
      held_samples[wr_slot[POS_BITS-1:0]] = s;
      mag  = longint'(s);
      if (mag < 0) mag = -mag;
      run_abs_sum += mag[SUM_BITS-1:0];
      produces = have_block;
      r.scaled = apply_gain(old, gain_now);
      r.gain   = gain_now;
      r.eob    = last;
      // new gain only after the end-of-block item has used the old one
      if (last) begin
         gain_now    = block_gain_for(len);
         run_abs_sum = '0;
         wr_slot     = 0;
         have_block  = 1'b1;
      end else begin
         wr_slot = wr_slot + 1;
      end
      return produces;
   endfunction

   function automatic void plan_csr(input logic [CSR_INDEX_BITS-1:0] idx, input int val);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.value = val[CSR_DATA_BITS-1:0];
      plan.push_back(row);
   endfunction

   function automatic void plan_item(input int s, input bit typed, input int scaled,
                                     input int gain, input bit eob);
      plan_row_type row;
      row               = '0;
      row.kind          = ROW_ITEM;
      row.sample        = s[SAMPLE_BITS-1:0];
      row.typed         = typed;
      row.result.scaled = scaled[OUT_BITS-1:0];
      row.result.gain   = gain[GAIN_BITS-1:0];
      row.result.eob    = eob;
      plan.push_back(row);
   endfunction

   // register write, mirrored at once
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      case (idx)
         CSR_BLOCK_LENGTH: cfg_block_length = val[LEN_BITS-1:0];
         CSR_TARGET_LEVEL: cfg_target       = val[LEVEL_BITS-1:0];
         CSR_LEVEL_FLOOR:  cfg_floor        = val[LEVEL_BITS-1:0];
         CSR_GAIN_MIN:     cfg_gain_min     = val[GAIN_BITS-1:0];
         CSR_GAIN_MAX:     cfg_gain_max     = val[GAIN_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // offer one sample; called and left at a falling edge
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit typed,
                              input scaled_item_type typed_result);
      int              gap;
      bit              produces;
      scaled_item_type predicted;
      gap = req_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= s;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      produces = predict_sample(s, predicted);
      if (typed) scaled_due.push_back(typed_result);
      else if (produces) scaled_due.push_back(predicted);
      @(negedge clock);
   endtask

   // wait for every expected item, then for any block-end division to finish
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (scaled_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result side: random stalls, compare against the oldest expectation
   initial begin
      int              stall;
      scaled_item_type got;
      scaled_item_type want;
      rsp_ch.ready <= 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         got.scaled = rsp_ch.scaled_sample;
         got.gain   = rsp_ch.applied_gain;
         got.eob    = rsp_ch.end_of_block;
         if (scaled_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected item: scaled_sample %0d applied_gain %0d end_of_block %0b",
                        $signed(got.scaled), got.gain, got.eob);
         end else begin
            want = scaled_due.pop_front();
            if (got.scaled !== want.scaled || got.gain !== want.gain || got.eob !== want.eob)
            begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: scaled_sample %0d/%0d applied_gain %0d/%0d %s %0b/%0b",
                           $signed(want.scaled), $signed(got.scaled), want.gain, got.gain,
                           "end_of_block (expected/actual)", want.eob, got.eob);
            end
         end
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      logic signed [SAMPLE_BITS-1:0] s;
      int r;
      int len;
      int amp;
      int mag;
      int count;
      int random_sent;
      req_ch.valid     <= 1'b0;
      req_ch.sample_in <= '0;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      random_sent = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one unity-gain block fills the first slots; later phases only read slots in it
      csr_write(CSR_BLOCK_LENGTH, PRIME_LEN);
      csr_write(CSR_GAIN_MIN, GAIN_ONE);
      csr_write(CSR_GAIN_MAX, GAIN_ONE);
      for (int n = 0; n < PRIME_LEN; n++) begin
         case (n)
            0: s = SAMPLE_MAX;
            1: s = SAMPLE_MIN;
            2: s = '0;
            3: s = '1;
            default: s = SAMPLE_BITS'($urandom);
         endcase
         send_sample(s, 1'b0, '0);
      end
      quiesce();

      // directed plan: unity, saturated-high and zero-level gains, min above max,
      // length changed mid-block to zero
      plan_csr(CSR_BLOCK_LENGTH, 4);
      plan_item(1, 1, 8388607, GAIN_ONE, 0);
      plan_item(-2, 1, -8388608, GAIN_ONE, 0);
      plan_item(4194304, 1, 0, GAIN_ONE, 0);
      plan_item(-4194305, 1, -1, GAIN_ONE, 1);
      plan_csr(CSR_TARGET_LEVEL, LEVEL_MAX);
      plan_csr(CSR_LEVEL_FLOOR, 0);
      plan_csr(CSR_GAIN_MIN, 0);
      plan_csr(CSR_GAIN_MAX, GAIN_MAX);
      plan_csr(CSR_SPARE_FIRST, LEVEL_MAX);
      plan_item(1, 1, 1, GAIN_ONE, 0);
      plan_item(-1, 1, -2, GAIN_ONE, 0);
      plan_item(1, 1, 4194304, GAIN_ONE, 0);
      plan_item(-1, 1, -4194305, GAIN_ONE, 1);
      // level one, huge gain clamped; negative products round down
      plan_item(0, 1, 15, GAIN_MAX, 0);
      plan_item(0, 1, -16, GAIN_MAX, 0);
      plan_item(0, 1, 15, GAIN_MAX, 0);
      plan_item(0, 1, -16, GAIN_MAX, 1);
      // zero level gives unity
      plan_item(8388607, 1, 0, GAIN_ONE, 0);
      plan_item(8388607, 1, 0, GAIN_ONE, 0);
      plan_item(8388607, 1, 0, GAIN_ONE, 0);
      plan_item(8388607, 1, 0, GAIN_ONE, 1);
      plan_csr(CSR_GAIN_MIN, GAIN_MAX);
      plan_csr(CSR_GAIN_MAX, 100);
      plan_item(-8388608, 1, 8388607, GAIN_ONE, 0);
      plan_item(5, 1, 8388607, GAIN_ONE, 0);
      plan_item(5, 1, 8388607, GAIN_ONE, 0);
      plan_item(5, 1, 8388607, GAIN_ONE, 1);
      // gain_max wins over gain_min
      plan_item(7, 1, -204800, 100, 0);
      plan_item(7, 1, 0, 100, 0);
      plan_csr(CSR_BLOCK_LENGTH, 0);
      plan_item(7, 1, 0, 100, 1);
      plan_item(7, 0, 0, 0, 0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (i == 0 || plan[i-1].kind != ROW_CSR) quiesce();
            csr_write(plan[i].index, int'(plan[i].value));
         end else begin
            send_sample(plan[i].sample, plan[i].typed, plan[i].result);
         end
      end

      // random phases, each under a fresh register setting
      while (random_sent < RANDOM_ITEMS) begin
         quiesce();
         r = $urandom_range(0, 99);
         if (r < 3) len = 0;
         else if (r < 8) len = 1;
         else if (r < 70) len = $urandom_range(2, 16);
         else if (r < 90) len = $urandom_range(17, 96);
         else if (r < 95) len = MAX_BLOCK;
         else len = LEN_FIELD_MAX;
         csr_write(CSR_BLOCK_LENGTH, len);
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
               0: csr_write(CSR_TARGET_LEVEL, 0);
               1: csr_write(CSR_TARGET_LEVEL, LEVEL_MAX);
               default: csr_write(CSR_TARGET_LEVEL, $urandom_range(0, LEVEL_MAX));
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 15))
               0, 1: csr_write(CSR_LEVEL_FLOOR, 0);
               2: csr_write(CSR_LEVEL_FLOOR, LEVEL_MAX);
               3, 4: csr_write(CSR_LEVEL_FLOOR, $urandom_range(0, LEVEL_MAX));
               default: csr_write(CSR_LEVEL_FLOOR, $urandom_range(0, 4096));
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
               0: csr_write(CSR_GAIN_MIN, 0);
               1: csr_write(CSR_GAIN_MIN, GAIN_MAX);
               default: csr_write(CSR_GAIN_MIN, $urandom_range(0, 8192));
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
               0: csr_write(CSR_GAIN_MAX, 0);
               1: csr_write(CSR_GAIN_MAX, GAIN_MAX);
               default: csr_write(CSR_GAIN_MAX, $urandom_range(2048, GAIN_MAX));
            endcase
         end
         if ($urandom_range(0, 5) == 0)
            csr_write(CSR_INDEX_BITS'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                      int'($urandom));

         // idling on both sides, sometimes off for a whole phase
         req_idles = ($urandom_range(0, 3) != 0);
         rsp_idles = ($urandom_range(0, 3) != 0);
         amp   = $urandom_range(0, SAMPLE_BITS - 2);
         count = $urandom_range(10, 90);
         // a long block may only run up to the last filled slot
         if (len >= MAX_BLOCK && count > PRIME_LEN - 1 - int'(wr_slot))
            count = PRIME_LEN - 1 - int'(wr_slot);
         repeat (count) begin
            r = $urandom_range(0, 15);
            if (r == 0) begin
               case ($urandom_range(0, 3))
                  0: s = SAMPLE_MAX;
                  1: s = SAMPLE_MIN;
                  2: s = '0;
                  default: s = '1;
               endcase
            end else if (r < 5) begin
               s = SAMPLE_BITS'($urandom);
            end else begin
               mag = $urandom_range(0, (1 << (amp + 1)) - 1);
               s   = $urandom_range(0, 1) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
            end
            send_sample(s, 1'b0, '0);
            random_sent++;
         end
      end

      quiesce();
      if (mismatch_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
sv/bgn_pkg.sv
sv/bgn_if.sv
sv/bgn_ram.sv
sv/bgn_divider.sv
sv/block_gain_normalizer.sv
sv/bgn_checker.sv
sim/tb_block_gain_normalizer.sv
